// File: sv/serial_command_frame_parser_core_assert.svh
// Assertion macros shared by the checker of the serial command frame parser.
`ifndef SERIAL_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfp checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is low.
`define SFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfp checker: next-cycle property failed");

`endif

// File: sv/sfp_pkg.sv
// Types and constants of the serial command frame parser.
package sfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int FRAME_BYTES = 5;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

    localparam logic [BYTE_W-1:0] CMD_START   = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_STOP    = 8'h31;
    localparam logic [BYTE_W-1:0] CMD_PAUSE   = 8'h32;
    localparam logic [BYTE_W-1:0] CMD_RAISE_Z = 8'h42;
    localparam logic [BYTE_W-1:0] CMD_LOWER_Z = 8'h41;

    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_START   = 3'd1,
        KIND_STOP    = 3'd2,
        KIND_PAUSE   = 3'd3,
        KIND_RAISE_Z = 3'd4,
        KIND_LOWER_Z = 3'd5
    } t_msg_type;

    typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] t_frame;

    typedef struct packed {
        logic close;   // chunk ends with this item
        logic exact;   // chunk holds exactly one frame length
    } t_chunk_info;

endpackage

// File: sv/sfp_collector.sv
// Byte counter and frame store: tracks the open chunk and decides when it closes.
module sfp_collector #(
    parameter int CHUNK_LIMIT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [sfp_pkg::BYTE_W-1:0]    i_byte,
    input  logic                          i_last,
    input  logic [sfp_pkg::BYTE_W-1:0]    i_end_marker,
    output sfp_pkg::t_frame               o_frame,
    output sfp_pkg::t_chunk_info          o_info
);

    localparam int CW = $clog2(CHUNK_LIMIT + 1);

    logic [CW-1:0]   r_count;
    sfp_pkg::t_frame r_store;
    logic [CW-1:0]   n_count;
    sfp_pkg::t_frame n_store;

    // Store view with the current byte dropped into its slot.
    always_comb begin
        n_store = r_store;
        for (int i = 0; i < sfp_pkg::FRAME_BYTES; i++) begin
            if (r_count == CW'(i)) begin
                n_store[i] = i_byte;
            end
        end
    end

    assign n_count = r_count + 1'b1;

    assign o_frame      = n_store;
    assign o_info.exact = (n_count == CW'(sfp_pkg::FRAME_BYTES));
    assign o_info.close = ((i_byte == i_end_marker) && (n_count >= CW'(sfp_pkg::FRAME_BYTES)))
                       || (n_count >= CW'(CHUNK_LIMIT))
                       || i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_store <= '0;
        end else if (i_adv) begin
            if (o_info.close) begin
                r_count <= '0;
                r_store <= '0;
            end else begin
                r_count <= n_count;
                r_store <= n_store;
            end
        end
    end

endmodule

// File: sv/sfp_check.sv
// Frame validation and command decode for a closed chunk.
module sfp_check (
    input  sfp_pkg::t_frame               i_frame,
    input  logic                          i_exact,
    input  logic [sfp_pkg::BYTE_W-1:0]    i_start_marker,
    input  logic [sfp_pkg::BYTE_W-1:0]    i_end_marker,
    output sfp_pkg::t_msg_type            o_msg_type,
    output logic [sfp_pkg::BYTE_W-1:0]    o_data_value
);

    logic                       good;
    logic [sfp_pkg::BYTE_W-1:0] sum12;
    sfp_pkg::t_msg_type         cmd;

    assign sum12 = i_frame[1] + i_frame[2];
    assign good  = i_exact
                && (i_frame[0] == i_start_marker)
                && (i_frame[4] == i_end_marker)
                && (i_frame[3] == sum12);

    always_comb begin
        unique case (i_frame[1])
            sfp_pkg::CMD_START:   cmd = sfp_pkg::KIND_START;
            sfp_pkg::CMD_STOP:    cmd = sfp_pkg::KIND_STOP;
            sfp_pkg::CMD_PAUSE:   cmd = sfp_pkg::KIND_PAUSE;
            sfp_pkg::CMD_RAISE_Z: cmd = sfp_pkg::KIND_RAISE_Z;
            sfp_pkg::CMD_LOWER_Z: cmd = sfp_pkg::KIND_LOWER_Z;
            default:              cmd = sfp_pkg::KIND_UNKNOWN;
        endcase
    end

    assign o_msg_type   = good ? cmd : sfp_pkg::KIND_UNKNOWN;
    assign o_data_value = good ? i_frame[2] : '0;

endmodule

// File: sv/serial_command_frame_parser_core.sv
// Serial command frame parser: top level with input, config and result registers.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one received byte and a
//   burst_end flag per item. Result channel (o_out_valid / i_out_stall) carries
//   one item per closed chunk: message type, data value and the first five raw
//   bytes of the chunk (zero where the chunk was shorter).
//   Config channel (i_cfg_valid / o_cfg_ready) writes the start marker (index 0)
//   and end marker (index 1); other indexes are ignored. It is always ready.
//   Path: a byte that closes a chunk is held in the input register, evaluated,
//   and its result is captured in the result register, which presents it.
//   Throughput: one byte per cycle while no held result blocks a closing byte,
//   set by the single evaluation stage between the input and result registers.
//   Stall: a held result blocks only a byte that would close another chunk;
//   bytes that do not close keep flowing. The input stalls once its register is
//   blocked.
//   Reset (synchronous, active low) clears both markers, the byte count, the
//   frame store and both valid flags.
module serial_command_frame_parser_core #(
    parameter int CHUNK_LIMIT = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_burst_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_msg_type,
    output logic [7:0]                      o_data_value,
    output logic [7:0]                      o_raw_byte0,
    output logic [7:0]                      o_raw_byte1,
    output logic [7:0]                      o_raw_byte2,
    output logic [7:0]                      o_raw_byte3,
    output logic [7:0]                      o_raw_byte4,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    logic [sfp_pkg::BYTE_W-1:0] r_start_marker;
    logic [sfp_pkg::BYTE_W-1:0] r_end_marker;

    logic                       r_in_valid;
    logic [sfp_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_in_last;

    logic                       r_out_valid;
    sfp_pkg::t_msg_type         r_msg_type;
    logic [sfp_pkg::BYTE_W-1:0] r_data_value;
    sfp_pkg::t_frame            r_raw;

    sfp_pkg::t_frame            frame;
    sfp_pkg::t_chunk_info       info;
    sfp_pkg::t_msg_type         n_msg_type;
    logic [sfp_pkg::BYTE_W-1:0] n_data_value;
    logic                       adv;
    logic                       in_acc;
    logic                       out_acc;

    sfp_collector #(
        .CHUNK_LIMIT (CHUNK_LIMIT)
    ) u_collector (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_end_marker (r_end_marker),
        .o_frame      (frame),
        .o_info       (info)
    );

    sfp_check u_check (
        .i_frame        (frame),
        .i_exact        (info.exact),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_msg_type     (n_msg_type),
        .o_data_value   (n_data_value)
    );

    // Advance the held byte unless it closes a chunk while a result is stuck.
    assign out_acc    = r_out_valid && !i_out_stall;
    assign adv        = r_in_valid && (!info.close || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= '0;
            r_end_marker   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfp_pkg::CFG_START_MARKER: r_start_marker <= i_cfg_data;
                sfp_pkg::CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_rx_byte;
            r_in_last <= i_burst_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && info.close) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && info.close) begin
            r_msg_type   <= n_msg_type;
            r_data_value <= n_data_value;
            r_raw        <= frame;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_msg_type   = r_msg_type;
    assign o_data_value = r_data_value;
    assign o_raw_byte0  = r_raw[0];
    assign o_raw_byte1  = r_raw[1];
    assign o_raw_byte2  = r_raw[2];
    assign o_raw_byte3  = r_raw[3];
    assign o_raw_byte4  = r_raw[4];

endmodule

// File: sv/sfp_checker.sv
// Port-level checker for the serial command frame parser, bound to the top level.
`include "serial_command_frame_parser_core_assert.svh"

module sfp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [2:0]                    o_msg_type,
    input logic [7:0]                    o_data_value,
    input logic [7:0]                    o_raw_byte1,
    input logic [7:0]                    o_raw_byte2,
    input logic [7:0]                    o_raw_byte3
);

    logic [7:0]  sum12;
    logic        known_cmd;
    logic        out_held;
    logic [10:0] out_word;
    logic        typed;
    logic        data_nz;

    assign sum12     = o_raw_byte1 + o_raw_byte2;
    assign known_cmd = (o_raw_byte1 == sfp_pkg::CMD_START)
                    || (o_raw_byte1 == sfp_pkg::CMD_STOP)
                    || (o_raw_byte1 == sfp_pkg::CMD_PAUSE)
                    || (o_raw_byte1 == sfp_pkg::CMD_RAISE_Z)
                    || (o_raw_byte1 == sfp_pkg::CMD_LOWER_Z);
    assign out_held  = o_out_valid && i_out_stall;
    assign out_word  = {o_msg_type, o_data_value};
    assign typed     = o_out_valid && (o_msg_type != sfp_pkg::KIND_UNKNOWN);
    assign data_nz   = o_out_valid && (o_data_value != 8'd0);

    // A stalled result stays and holds its message type and data value.
    `SFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_word))
    // A decoded command carries byte two as its data value.
    `SFP_ASSERT_NOW(a_type_data, i_clk, i_rst_n, typed, o_data_value == o_raw_byte2)
    // A nonzero data value only comes from a frame whose checksum matched.
    `SFP_ASSERT_NOW(a_data_sum, i_clk, i_rst_n, data_nz, o_raw_byte3 == sum12)
    // A decoded command only comes from a known command byte.
    `SFP_ASSERT_NOW(a_type_cmd, i_clk, i_rst_n, typed, known_cmd)

endmodule

bind serial_command_frame_parser_core sfp_checker u_sfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_msg_type   (o_msg_type),
    .o_data_value (o_data_value),
    .o_raw_byte1  (o_raw_byte1),
    .o_raw_byte2  (o_raw_byte2),
    .o_raw_byte3  (o_raw_byte3)
);

// File: dv/serial_command_frame_parser_checker.sv
// Checker for the serial command frame parser: predicts each closed chunk and compares results.
module serial_command_frame_parser_checker #(
    parameter int CHUNK_LIMIT = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [7:0]                i_rx_byte,
    input  logic                      i_burst_end,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [2:0]                i_msg_type,
    input  logic [7:0]                i_data_value,
    input  logic [7:0]                i_raw_byte0,
    input  logic [7:0]                i_raw_byte1,
    input  logic [7:0]                i_raw_byte2,
    input  logic [7:0]                i_raw_byte3,
    input  logic [7:0]                i_raw_byte4,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [sfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                i_cfg_data,
    output int                        o_fail_count,
    output int                        o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sfp_pkg::t_msg_type msg;
        logic [7:0]         data;
        sfp_pkg::t_frame    raw;
    } t_frame_result;

    logic [7:0]      start_marker_q = '0;
    logic [7:0]      end_marker_q   = '0;
    sfp_pkg::t_frame chunk_bytes    = '0;
    logic [5:0]      chunk_count    = '0;
    t_frame_result   results_due[$];
    int              fail_count     = 0;
    int              due_count      = 0;

    assign o_fail_count  = fail_count;
    assign o_results_due = due_count;

    function automatic sfp_pkg::t_msg_type decode_command(input logic [7:0] cmd);
        case (cmd)
            sfp_pkg::CMD_START:   return sfp_pkg::KIND_START;
            sfp_pkg::CMD_STOP:    return sfp_pkg::KIND_STOP;
            sfp_pkg::CMD_PAUSE:   return sfp_pkg::KIND_PAUSE;
            sfp_pkg::CMD_RAISE_Z: return sfp_pkg::KIND_RAISE_Z;
            sfp_pkg::CMD_LOWER_Z: return sfp_pkg::KIND_LOWER_Z;
            default:              return sfp_pkg::KIND_UNKNOWN;
        endcase
    endfunction

    // Advance the chunk by one byte; return 1 with the result when the chunk closes.
    function automatic logic parse_rx_byte(input logic [7:0] rx, input logic last,
                                           output t_frame_result res);
        logic closes;
        if (chunk_count < sfp_pkg::FRAME_BYTES)
            chunk_bytes[chunk_count] = rx;
        chunk_count = chunk_count + 1'b1;
        closes = (rx == end_marker_q && chunk_count >= sfp_pkg::FRAME_BYTES)
              || chunk_count >= CHUNK_LIMIT || last;
        res = '0;
        if (!closes)
            return 1'b0;
        res.msg  = sfp_pkg::KIND_UNKNOWN;
        res.raw  = chunk_bytes;
        if (chunk_count == sfp_pkg::FRAME_BYTES && chunk_bytes[0] == start_marker_q
            && chunk_bytes[4] == end_marker_q
            && chunk_bytes[3] == 8'(chunk_bytes[1] + chunk_bytes[2])) begin
            res.data = chunk_bytes[2];
            res.msg  = decode_command(chunk_bytes[1]);
        end
        chunk_bytes = '0;
        chunk_count = '0;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result res;
        t_frame_result want;
        if (!i_rst_n) begin
            start_marker_q = '0;
            end_marker_q   = '0;
            chunk_bytes    = '0;
            chunk_count    = '0;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sfp_pkg::CFG_START_MARKER: start_marker_q = i_cfg_data;
                    sfp_pkg::CFG_END_MARKER:   end_marker_q   = i_cfg_data;
                    default: ;
                endcase
            end
            // Compare before predicting so a stray result never meets a fresh expectation.
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result item with no expected frame pending");
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("msg_type",   8'(want.msg), 8'(i_msg_type));
                    check_field("data_value", want.data,    i_data_value);
                    check_field("raw_byte0",  want.raw[0],  i_raw_byte0);
                    check_field("raw_byte1",  want.raw[1],  i_raw_byte1);
                    check_field("raw_byte2",  want.raw[2],  i_raw_byte2);
                    check_field("raw_byte3",  want.raw[3],  i_raw_byte3);
                    check_field("raw_byte4",  want.raw[4],  i_raw_byte4);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (parse_rx_byte(i_rx_byte, i_burst_end, res))
                    results_due.push_back(res);
            end
        end
        due_count = results_due.size();
    end

endmodule

// File: dv/tb_serial_command_frame_parser_core.sv
// Testbench top for the serial command frame parser: clock, reset, stimulus and verdict.
module tb_serial_command_frame_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHUNK_LIMIT  = 32;
    localparam int IDLE_LIMIT   = 3000;
    localparam int SETTLE_TICKS = 4;
    localparam int DRAIN_TICKS  = 8;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 270;
    localparam logic [sfp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [sfp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic [7:0]                    i_rx_byte   = '0;
    logic                          i_burst_end = 1'b0;
    logic                          i_out_stall = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [sfp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]                    i_cfg_data  = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [2:0]                    o_msg_type;
    logic [7:0]                    o_data_value;
    logic [7:0]                    o_raw_byte0;
    logic [7:0]                    o_raw_byte1;
    logic [7:0]                    o_raw_byte2;
    logic [7:0]                    o_raw_byte3;
    logic [7:0]                    o_raw_byte4;
    logic                          o_cfg_ready;
    int                            fail_count;
    int                            results_due;

    logic [7:0] cur_start = '0;
    logic [7:0] cur_end   = '0;
    logic [7:0] cmd_set [5] = '{sfp_pkg::CMD_START, sfp_pkg::CMD_STOP, sfp_pkg::CMD_PAUSE,
                                sfp_pkg::CMD_RAISE_Z, sfp_pkg::CMD_LOWER_Z};
    int         burst_left  = 0;
    int         phase_sent  = 0;
    int         idle_cycles = 0;
    int         stall_mode  = 0;
    int         stall_left  = 0;
    int         stall_tick  = 0;

    serial_command_frame_parser_core #(
        .CHUNK_LIMIT (CHUNK_LIMIT)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .i_burst_end  (i_burst_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_msg_type   (o_msg_type),
        .o_data_value (o_data_value),
        .o_raw_byte0  (o_raw_byte0),
        .o_raw_byte1  (o_raw_byte1),
        .o_raw_byte2  (o_raw_byte2),
        .o_raw_byte3  (o_raw_byte3),
        .o_raw_byte4  (o_raw_byte4),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    serial_command_frame_parser_checker #(
        .CHUNK_LIMIT (CHUNK_LIMIT)
    ) u_frame_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .i_burst_end   (i_burst_end),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_msg_type    (o_msg_type),
        .i_data_value  (o_data_value),
        .i_raw_byte0   (o_raw_byte0),
        .i_raw_byte1   (o_raw_byte1),
        .i_raw_byte2   (o_raw_byte2),
        .i_raw_byte3   (o_raw_byte3),
        .i_raw_byte4   (o_raw_byte4),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stall: switch between no stall, light, heavy and periodic patterns.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 9) < 3);
            2:       i_out_stall <= ($urandom_range(0, 9) < 7);
            default: i_out_stall <= (stall_tick % 7) < 3;
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_serial_command_frame_parser_core: errors");
            $finish;
        end
    end

    // All tasks start and end at a falling edge with nothing yet driven in that step.
    task automatic send_byte(input logic [7:0] rx, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                       : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_rx_byte   <= rx;
        i_burst_end <= last;
        do @(posedge i_clk); while (o_in_stall);
        phase_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic [7:0] b4, input logic last);
        send_byte(b0, 1'b0);
        send_byte(b1, 1'b0);
        send_byte(b2, 1'b0);
        send_byte(b3, 1'b0);
        send_byte(b4, last);
    endtask

    // Hold the sender until every expected result is out, then let the pipe settle.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        burst_left = 0;
        wait (results_due == 0);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [sfp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] avoid_end(input logic [7:0] rx);
        return (rx == cur_end) ? (rx ^ 8'h01) : rx;
    endfunction

    task automatic run_random_phase(input int n_items);
        int         pick;
        int         len;
        logic [7:0] cmd;
        logic [7:0] data;
        logic [7:0] sum;
        phase_sent = 0;
        while (phase_sent < n_items) begin
            pick = $urandom_range(0, 99);
            cmd  = ($urandom_range(0, 99) < 85) ? cmd_set[$urandom_range(0, 4)]
                                                : 8'($urandom);
            data = 8'($urandom);
            sum  = 8'(cmd + data);
            if (pick < 55) begin
                send_frame(cur_start, cmd, data, sum, cur_end, $urandom_range(0, 3) == 0);
            end else if (pick < 70) begin
                case ($urandom_range(0, 4))
                    0: send_frame(cur_start ^ 8'($urandom_range(1, 255)), cmd, data, sum,
                                  cur_end, 1'b0);
                    1: send_frame(cur_start, cmd, data, sum ^ 8'($urandom_range(1, 255)),
                                  cur_end, 1'b0);
                    2: send_frame(cur_start, cmd, data, sum,
                                  cur_end ^ 8'($urandom_range(1, 255)), 1'b1);
                    3: begin
                        // Six bytes: the frame closes one byte late.
                        send_frame(cur_start, cmd, data, sum, avoid_end(8'($urandom)), 1'b0);
                        send_byte(cur_end, 1'b0);
                    end
                    default: begin
                        send_byte(cur_start, 1'b0);
                        send_byte(cmd, 1'b0);
                        send_byte(data, 1'b0);
                        send_byte(sum, 1'b1);
                    end
                endcase
            end else if (pick < 88) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    send_byte(8'($urandom), (k == len - 1) || ($urandom_range(0, 9) == 0));
            end else if (pick < 96) begin
                // Long run without end markers that can reach the chunk limit.
                len = $urandom_range(CHUNK_LIMIT - 2, 2 * CHUNK_LIMIT + 5);
                for (int k = 0; k < len; k++)
                    send_byte(avoid_end(8'($urandom)), k == len - 1);
            end else begin
                quiesce();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at reset markers (both zero).
        send_frame(8'h00, sfp_pkg::CMD_START, 8'h00, sfp_pkg::CMD_START, 8'h00, 1'b0);
        send_frame(8'h00, sfp_pkg::CMD_RAISE_Z, 8'hFF, 8'(sfp_pkg::CMD_RAISE_Z + 8'hFF),
                   8'h00, 1'b1);
        send_frame(8'h00, 8'hFF, 8'h01, 8'h00, 8'h00, 1'b0);
        send_byte(8'hAB, 1'b1);
        send_frame(8'h00, sfp_pkg::CMD_STOP, 8'h10, 8'h00, 8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            quiesce();
            case (p)
                0:       begin cur_start = 8'hFF; cur_end = 8'hFF; end
                1:       begin cur_start = 8'h00; cur_end = 8'hFF; end
                2:       begin cur_start = 8'hFF; cur_end = 8'h00; end
                3:       begin cur_start = 8'h7E; cur_end = 8'h7E; end
                default: begin cur_start = 8'($urandom); cur_end = 8'($urandom); end
            endcase
            cfg_write(sfp_pkg::CFG_START_MARKER, cur_start);
            cfg_write(sfp_pkg::CFG_END_MARKER, cur_end);
            if (p == 1) begin
                // Unused indexes must leave both markers alone.
                cfg_write(CFG_SPARE_A, 8'($urandom));
                cfg_write(CFG_SPARE_B, 8'($urandom));
            end
            run_random_phase(PHASE_ITEMS);
        end

        quiesce();
        repeat (DRAIN_TICKS) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_serial_command_frame_parser_core: clean");
        else
            $display("tb_serial_command_frame_parser_core: errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/sfp_pkg.sv
sv/sfp_collector.sv
sv/sfp_check.sv
sv/serial_command_frame_parser_core.sv
sv/sfp_checker.sv
dv/serial_command_frame_parser_checker.sv
dv/tb_serial_command_frame_parser_core.sv
